[sv/tga_truecolor_stream_decoder_top_macros.svh]
// Assertion macros used by the port-level checker of the TGA stream decoder.
`ifndef TGA_TRUECOLOR_STREAM_DECODER_TOP_MACROS_SVH
`define TGA_TRUECOLOR_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define TGAD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgad: same-cycle check failed");

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define TGAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgad: next-cycle check failed");

`endif

[sv/tgad_pkg.sv]
// Shared types and constants of the TGA true-color stream decoder.
package tgad_pkg;

    // Largest accepted image side, in pixels.
    localparam int MAX_SIDE = 4096;

    // Header layout and accepted format codes.
    localparam logic [4:0] POS_TYPE      = 5'd2;
    localparam logic [4:0] POS_WIDTH_LO  = 5'd12;
    localparam logic [4:0] POS_WIDTH_HI  = 5'd13;
    localparam logic [4:0] POS_HEIGHT_LO = 5'd14;
    localparam logic [4:0] POS_HEIGHT_HI = 5'd15;
    localparam logic [4:0] POS_DEPTH     = 5'd16;
    localparam logic [4:0] POS_DESC      = 5'd17;

    localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
    localparam logic [7:0] DEPTH_24       = 8'd24;
    localparam logic [7:0] DEPTH_32       = 8'd32;
    localparam logic [3:0] ORIGIN_LOWER   = 4'h0;
    localparam logic [3:0] ORIGIN_ALPHA8  = 4'h8;

    localparam logic [2:0] BPP_NONE = 3'd0;
    localparam logic [2:0] BPP_24   = 3'd3;
    localparam logic [2:0] BPP_32   = 3'd4;

    // Queue sizes.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = CMD_PTR_W + 1;
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = RES_PTR_W + 1;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    // One input word: a byte of the file.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } in_word_t;

    // One result word.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [2:0]  bytes_per_pixel;
        logic [23:0] pixel_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last_pixel;
    } out_word_t;

    // Command passed from the parser to the executor.
    typedef struct packed {
        logic        is_header;
        logic [7:0]  type_code;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  depth_bits;
        logic [7:0]  descriptor_bits;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
    } cmd_t;

    // Status of the command queue as seen by its neighbors.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Parser phases.
    typedef enum logic [2:0] {
        FR_IDLE   = 3'b001,
        FR_HEADER = 3'b010,
        FR_PIXELS = 3'b100
    } front_phase_t;

    // Executor phases.
    typedef enum logic [1:0] {
        BK_IDLE   = 2'b01,
        BK_PIXELS = 2'b10
    } back_phase_t;

endpackage

[sv/tga_truecolor_stream_decoder_top.sv]
// Decodes an uncompressed true-color TGA byte stream into header and pixel words.
// The decoder takes one file byte per clock for as long as the result side keeps
// popping: a parser classifies each byte and hands finished headers and pixels to
// an executor through a four-word command queue, and the executor writes result
// words into a four-word result queue. The word that completes a header or pixel
// is visible on the result ports after the command queue and then the result queue.
// full rises only when the result queue has filled and then the command queue
// behind it; the executor's single (height - 1) * width multiply on each header
// sets the longest path, and it never stalls the stream. A byte with file_start
// high begins a new 18-byte header at once, dropping whatever was in progress.
module tga_truecolor_stream_decoder_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  tgad_pkg::in_word_t   item,
    output logic                 empty,
    input  logic                 pop,
    output tgad_pkg::out_word_t  result
);

    logic                     accept;
    logic                     cmd_push;
    logic                     cmd_pop;
    tgad_pkg::cmd_t           cmd_in;
    tgad_pkg::cmd_t           cmd_out;
    tgad_pkg::queue_status_t  cmd_status;

    assign full   = cmd_status.full;
    assign accept = push && !cmd_status.full;

    // Byte parser.
    tgad_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    // Queue between parser and executor.
    tgad_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .status  (cmd_status)
    );

    // Executor and result queue.
    tgad_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_status.empty),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

[sv/tgad_front.sv]
// Byte parser: collects the header and groups pixel bytes into commands.
module tgad_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  tgad_pkg::in_word_t  item,
    output logic                cmd_push,
    output tgad_pkg::cmd_t      cmd
);

    tgad_pkg::front_phase_t phase_reg, phase_next, eff_phase;
    logic [4:0]  hdr_pos_reg, hdr_pos_next, eff_pos;
    logic [1:0]  byte_cnt_reg, byte_cnt_next;
    logic [7:0]  type_reg, type_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  depth_reg, depth_next;
    logic [7:0]  blue_reg, blue_next;
    logic [7:0]  green_reg, green_next;
    logic [7:0]  red_reg, red_next;
    logic [7:0]  b;
    logic        four_bytes;

    assign b          = item.data_byte;
    assign four_bytes = (depth_reg != tgad_pkg::DEPTH_24);

    // A file start restarts the header at byte zero, whatever was in progress.
    assign eff_phase = item.file_start ? tgad_pkg::FR_HEADER : phase_reg;
    assign eff_pos   = item.file_start ? 5'd0 : hdr_pos_reg;

    // Next-state and command build.
    always_comb
    begin
        phase_next    = phase_reg;
        hdr_pos_next  = hdr_pos_reg;
        byte_cnt_next = byte_cnt_reg;
        type_next     = type_reg;
        width_next    = width_reg;
        height_next   = height_reg;
        depth_next    = depth_reg;
        blue_next     = blue_reg;
        green_next    = green_reg;
        red_next      = red_reg;
        cmd_push      = 1'b0;
        cmd           = '0;
        if (accept)
        begin
            phase_next = eff_phase;
            unique case (eff_phase)
                tgad_pkg::FR_HEADER:
                begin
                    hdr_pos_next = eff_pos + 5'd1;
                    unique case (eff_pos)
                        tgad_pkg::POS_TYPE:      type_next   = b;
                        tgad_pkg::POS_WIDTH_LO:  width_next  = {width_reg[15:8], b};
                        tgad_pkg::POS_WIDTH_HI:  width_next  = {b, width_reg[7:0]};
                        tgad_pkg::POS_HEIGHT_LO: height_next = {height_reg[15:8], b};
                        tgad_pkg::POS_HEIGHT_HI: height_next = {b, height_reg[7:0]};
                        tgad_pkg::POS_DEPTH:     depth_next  = b;
                        tgad_pkg::POS_DESC:
                        begin
                            cmd_push            = 1'b1;
                            cmd.is_header       = 1'b1;
                            cmd.type_code       = type_reg;
                            cmd.width           = width_reg;
                            cmd.height          = height_reg;
                            cmd.depth_bits      = depth_reg;
                            cmd.descriptor_bits = b;
                            phase_next          = tgad_pkg::FR_PIXELS;
                            byte_cnt_next       = 2'd0;
                        end
                        default: ;
                    endcase
                end
                tgad_pkg::FR_PIXELS:
                begin
                    // Stored order is blue, green, red, then alpha for 32-bit pixels.
                    unique case (byte_cnt_reg)
                        2'd0:
                        begin
                            blue_next     = b;
                            byte_cnt_next = 2'd1;
                        end
                        2'd1:
                        begin
                            green_next    = b;
                            byte_cnt_next = 2'd2;
                        end
                        2'd2:
                        begin
                            red_next = b;
                            if (four_bytes)
                            begin
                                byte_cnt_next = 2'd3;
                            end
                            else
                            begin
                                byte_cnt_next = 2'd0;
                                cmd_push      = 1'b1;
                                cmd.red       = b;
                                cmd.green     = green_reg;
                                cmd.blue      = blue_reg;
                            end
                        end
                        default:
                        begin
                            byte_cnt_next = 2'd0;
                            cmd_push      = 1'b1;
                            cmd.red       = red_reg;
                            cmd.green     = green_reg;
                            cmd.blue      = blue_reg;
                            cmd.alpha     = b;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= tgad_pkg::FR_IDLE;
            hdr_pos_reg  <= 5'd0;
            byte_cnt_reg <= 2'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            hdr_pos_reg  <= hdr_pos_next;
            byte_cnt_reg <= byte_cnt_next;
        end
    end

    // Header fields and partial pixel.
    always_ff @(posedge clk)
    begin
        type_reg   <= type_next;
        width_reg  <= width_next;
        height_reg <= height_next;
        depth_reg  <= depth_next;
        blue_reg   <= blue_next;
        green_reg  <= green_next;
        red_reg    <= red_next;
    end

endmodule

[sv/tgad_cmd_queue.sv]
// Short command queue between the parser and the executor.
module tgad_cmd_queue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  tgad_pkg::cmd_t           wr_data,
    input  logic                     rd_en,
    output tgad_pkg::cmd_t           rd_data,
    output tgad_pkg::queue_status_t  status
);

    tgad_pkg::cmd_t                    slot_reg [tgad_pkg::CMD_DEPTH];
    logic [tgad_pkg::CMD_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tgad_pkg::CMD_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tgad_pkg::CMD_CNT_W-1:0]    count_reg, count_next;
    logic                              do_wr, do_rd;

    assign status.full  = (count_reg == tgad_pkg::CMD_CNT_W'(tgad_pkg::CMD_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_data      = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == tgad_pkg::CMD_PTR_W'(tgad_pkg::CMD_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == tgad_pkg::CMD_PTR_W'(tgad_pkg::CMD_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[sv/tgad_back.sv]
// Executor: checks headers, tracks the raster position and queues result words.
module tgad_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  tgad_pkg::cmd_t           cmd,
    input  logic                     cmd_empty,
    output logic                     cmd_pop,
    input  logic                     pop,
    output logic                     empty,
    output tgad_pkg::out_word_t      result
);

    tgad_pkg::back_phase_t            phase_reg, phase_next;
    logic [15:0]                      width_reg, width_next;
    logic [15:0]                      height_reg, height_next;
    logic [2:0]                       bpp_reg, bpp_next;
    logic [12:0]                      col_reg, col_next;
    logic [12:0]                      rows_left_reg, rows_left_next;
    logic [23:0]                      row_base_reg, row_base_next;
    tgad_pkg::out_word_t              res_word;
    logic                             res_push;
    logic                             header_ok;
    logic [3:0]                       origin;
    logic [15:0]                      height_less_one;
    logic [31:0]                      base_product;
    logic [15:0]                      col_plus_one;
    logic                             is_last;

    tgad_pkg::out_word_t              res_slot_reg [tgad_pkg::RES_DEPTH];
    logic [tgad_pkg::RES_PTR_W-1:0]   res_wr_ptr_reg, res_wr_ptr_next;
    logic [tgad_pkg::RES_PTR_W-1:0]   res_rd_ptr_reg, res_rd_ptr_next;
    logic [tgad_pkg::RES_CNT_W-1:0]   res_count_reg, res_count_next;
    logic                             res_full;
    logic                             res_pop;

    // A command is taken whenever there is room for the word it may produce.
    assign res_full = (res_count_reg == tgad_pkg::RES_CNT_W'(tgad_pkg::RES_DEPTH));
    assign cmd_pop  = !cmd_empty && !res_full;

    // Header acceptance test.
    assign origin    = cmd.descriptor_bits[3:0];
    assign header_ok = (cmd.type_code == tgad_pkg::TYPE_TRUECOLOR)
                    && (cmd.depth_bits == tgad_pkg::DEPTH_24
                        || cmd.depth_bits == tgad_pkg::DEPTH_32)
                    && (origin == tgad_pkg::ORIGIN_LOWER
                        || origin == tgad_pkg::ORIGIN_ALPHA8)
                    && (cmd.width <= 16'(tgad_pkg::MAX_SIDE))
                    && (cmd.height <= 16'(tgad_pkg::MAX_SIDE));

    // Index of the first pixel of the bottom row: (height - 1) * width.
    assign height_less_one = cmd.height - 16'd1;
    assign base_product    = height_less_one * cmd.width;

    assign col_plus_one = {3'b000, col_reg} + 16'd1;
    assign is_last      = (rows_left_reg == 13'd1) && (col_plus_one == width_reg);

    // Command execution.
    always_comb
    begin
        phase_next     = phase_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        bpp_next       = bpp_reg;
        col_next       = col_reg;
        rows_left_next = rows_left_reg;
        row_base_next  = row_base_reg;
        res_push       = 1'b0;
        res_word       = '0;
        if (cmd_pop)
        begin
            if (cmd.is_header)
            begin
                res_push              = 1'b1;
                res_word.image_width  = cmd.width;
                res_word.image_height = cmd.height;
                width_next            = cmd.width;
                height_next           = cmd.height;
                col_next              = 13'd0;
                rows_left_next        = cmd.height[12:0];
                row_base_next         = base_product[23:0];
                if (!header_ok)
                begin
                    res_word.kind = tgad_pkg::KIND_ERROR;
                    phase_next    = tgad_pkg::BK_IDLE;
                    bpp_next      = tgad_pkg::BPP_NONE;
                end
                else
                begin
                    res_word.kind            = tgad_pkg::KIND_HEADER;
                    bpp_next                 = (cmd.depth_bits == tgad_pkg::DEPTH_24)
                                             ? tgad_pkg::BPP_24 : tgad_pkg::BPP_32;
                    res_word.bytes_per_pixel = bpp_next;
                    // An empty image produces no pixels at all.
                    phase_next = (cmd.width == 16'd0 || cmd.height == 16'd0)
                               ? tgad_pkg::BK_IDLE : tgad_pkg::BK_PIXELS;
                end
            end
            else if (phase_reg == tgad_pkg::BK_PIXELS)
            begin
                res_push                 = 1'b1;
                res_word.kind            = tgad_pkg::KIND_PIXEL;
                res_word.image_width     = width_reg;
                res_word.image_height    = height_reg;
                res_word.bytes_per_pixel = bpp_reg;
                res_word.pixel_index     = row_base_reg + {11'd0, col_reg};
                res_word.red             = cmd.red;
                res_word.green           = cmd.green;
                res_word.blue            = cmd.blue;
                res_word.alpha           = cmd.alpha;
                res_word.last_pixel      = is_last;
                // Rows are stored bottom-up: each finished row moves the base one row up.
                if (col_plus_one >= width_reg)
                begin
                    col_next       = 13'd0;
                    rows_left_next = rows_left_reg - 13'd1;
                    row_base_next  = row_base_reg - {8'd0, width_reg};
                end
                else
                begin
                    col_next = col_plus_one[12:0];
                end
                if (is_last)
                begin
                    phase_next = tgad_pkg::BK_IDLE;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tgad_pkg::BK_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg     <= width_next;
        height_reg    <= height_next;
        bpp_reg       <= bpp_next;
        col_reg       <= col_next;
        rows_left_reg <= rows_left_next;
        row_base_reg  <= row_base_next;
    end

    // Result queue: the oldest word is shown while the queue is not empty.
    assign empty   = (res_count_reg == '0);
    assign res_pop = pop && !empty;
    assign result  = res_slot_reg[res_rd_ptr_reg];

    always_comb
    begin
        res_wr_ptr_next = res_wr_ptr_reg;
        res_rd_ptr_next = res_rd_ptr_reg;
        res_count_next  = res_count_reg;
        if (res_push)
        begin
            res_wr_ptr_next = (res_wr_ptr_reg == tgad_pkg::RES_PTR_W'(tgad_pkg::RES_DEPTH - 1))
                            ? '0 : res_wr_ptr_reg + 1'b1;
        end
        if (res_pop)
        begin
            res_rd_ptr_next = (res_rd_ptr_reg == tgad_pkg::RES_PTR_W'(tgad_pkg::RES_DEPTH - 1))
                            ? '0 : res_rd_ptr_reg + 1'b1;
        end
        if (res_push && !res_pop)
        begin
            res_count_next = res_count_reg + 1'b1;
        end
        else if (res_pop && !res_push)
        begin
            res_count_next = res_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= '0;
            res_rd_ptr_reg <= '0;
            res_count_reg  <= '0;
        end
        else
        begin
            res_wr_ptr_reg <= res_wr_ptr_next;
            res_rd_ptr_reg <= res_rd_ptr_next;
            res_count_reg  <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_slot_reg[res_wr_ptr_reg] <= res_word;
        end
    end

endmodule

[sv/tgad_checker.sv]
// Port-level checker for the TGA stream decoder and its bind to the top level.
`include "tga_truecolor_stream_decoder_top_macros.svh"

module tgad_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 empty,
    input  logic                 pop,
    input  tgad_pkg::out_word_t  result
);

    logic showing_pixel;
    logic showing_error;
    logic pixel_bpp_ok;
    logic error_clean;
    logic last_index_ok;

    // Decoded views of the word on the result ports.
    assign showing_pixel = !empty && (result.kind == tgad_pkg::KIND_PIXEL);
    assign showing_error = !empty && (result.kind == tgad_pkg::KIND_ERROR);
    assign pixel_bpp_ok  = (result.bytes_per_pixel == tgad_pkg::BPP_24)
                        || (result.bytes_per_pixel == tgad_pkg::BPP_32);
    assign error_clean   = (result.bytes_per_pixel == tgad_pkg::BPP_NONE)
                        && (result.pixel_index == 24'd0) && !result.last_pixel;
    assign last_index_ok = (result.kind == tgad_pkg::KIND_PIXEL)
                        && (result.pixel_index == {8'd0, result.image_width} - 24'd1);

    // A waiting word that is not popped stays, unchanged.
    `TGAD_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(result))

    // Pixel words always carry a real pixel size.
    `TGAD_ASSERT_IMPLY(a_pixel_bpp, showing_pixel, pixel_bpp_ok)

    // Error words carry only the raw sides.
    `TGAD_ASSERT_IMPLY(a_error_clean, showing_error, error_clean)

    // The last pixel is the right end of the top destination row.
    `TGAD_ASSERT_IMPLY(a_last_index, !empty && result.last_pixel, last_index_ok)

endmodule

bind tga_truecolor_stream_decoder_top tgad_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

[bench/tga_truecolor_stream_decoder_checker.sv]
// Checker for the TGA stream decoder: predicts result words and compares them.
`timescale 1ns / 1ps

module tga_truecolor_stream_decoder_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic                 full,
    input  tgad_pkg::in_word_t   item,
    input  logic                 empty,
    input  logic                 pop,
    input  tgad_pkg::out_word_t  result,
    output int                   fail_count,
    output int                   words_pending
);

    typedef enum logic [2:0] {
        PARSE_IDLE   = 3'b001,
        PARSE_HEADER = 3'b010,
        PARSE_PIXELS = 3'b100
    } parse_phase_t;

    // Decoder state as this checker tracks it.
    parse_phase_t phase;
    logic [4:0]   hdr_pos;
    logic [7:0]   img_type;
    logic [7:0]   pix_depth;
    logic [7:0]   desc_bits;
    logic [15:0]  img_w;
    logic [15:0]  img_h;
    logic [23:0]  pix_acc;
    logic [1:0]   pix_bytes;
    logic [12:0]  col;
    logic [12:0]  rows_left;
    logic [23:0]  row_base;

    // Words the decoder still owes, oldest first.
    tgad_pkg::out_word_t decoded_q[$];
    int                  mismatches;

    assign fail_count = mismatches;

    task automatic clear_decoder();
        phase     = PARSE_IDLE;
        hdr_pos   = '0;
        img_type  = '0;
        pix_depth = '0;
        desc_bits = '0;
        img_w     = '0;
        img_h     = '0;
        pix_acc   = '0;
        pix_bytes = '0;
        col       = '0;
        rows_left = '0;
        row_base  = '0;
    endtask

    // Advance the decoder by one accepted byte and queue the word it produces, if any.
    task automatic decode_byte(input tgad_pkg::in_word_t w);
        tgad_pkg::out_word_t r;
        logic [7:0]          b;
        logic [2:0]          bpp;
        logic [7:0]          alpha;
        logic [31:0]         base;
        logic                ok;
        logic                emit;
        logic                last;
        b = w.data_byte;
        r = '0;
        if (w.file_start)
        begin
            clear_decoder();
            phase = PARSE_HEADER;
        end
        if (phase == PARSE_HEADER)
        begin
            case (hdr_pos)
                tgad_pkg::POS_TYPE:      img_type = b;
                tgad_pkg::POS_WIDTH_LO:  img_w[7:0] = b;
                tgad_pkg::POS_WIDTH_HI:  img_w[15:8] = b;
                tgad_pkg::POS_HEIGHT_LO: img_h[7:0] = b;
                tgad_pkg::POS_HEIGHT_HI: img_h[15:8] = b;
                tgad_pkg::POS_DEPTH:     pix_depth = b;
                tgad_pkg::POS_DESC:      desc_bits = b;
                default:                 ;
            endcase
            if (hdr_pos == tgad_pkg::POS_DESC)
            begin
                // The last header byte decides between a header word and an error word.
                ok = (img_type == tgad_pkg::TYPE_TRUECOLOR)
                    && (pix_depth == tgad_pkg::DEPTH_24 || pix_depth == tgad_pkg::DEPTH_32)
                    && (desc_bits[3:0] == tgad_pkg::ORIGIN_LOWER
                        || desc_bits[3:0] == tgad_pkg::ORIGIN_ALPHA8)
                    && (32'(img_w) <= tgad_pkg::MAX_SIDE)
                    && (32'(img_h) <= tgad_pkg::MAX_SIDE);
                r.image_width  = img_w;
                r.image_height = img_h;
                if (!ok)
                begin
                    r.kind = tgad_pkg::KIND_ERROR;
                    phase  = PARSE_IDLE;
                end
                else
                begin
                    r.kind            = tgad_pkg::KIND_HEADER;
                    r.bytes_per_pixel = (pix_depth == tgad_pkg::DEPTH_24)
                                      ? tgad_pkg::BPP_24 : tgad_pkg::BPP_32;
                    pix_acc   = '0;
                    pix_bytes = '0;
                    col       = '0;
                    if (img_w == 16'd0 || img_h == 16'd0)
                    begin
                        phase     = PARSE_IDLE;
                        rows_left = '0;
                        row_base  = '0;
                    end
                    else
                    begin
                        phase     = PARSE_PIXELS;
                        rows_left = img_h[12:0];
                        base      = (32'(img_h) - 32'd1) * 32'(img_w);
                        row_base  = base[23:0];
                    end
                end
                decoded_q.push_back(r);
            end
            hdr_pos = hdr_pos + 5'd1;
        end
        else if (phase == PARSE_PIXELS)
        begin
            bpp   = (pix_depth == tgad_pkg::DEPTH_24) ? tgad_pkg::BPP_24 : tgad_pkg::BPP_32;
            alpha = '0;
            emit  = 1'b1;
            // Color bytes arrive blue first; a fourth byte is alpha.
            if (pix_bytes < 2'd3)
            begin
                pix_acc   = pix_acc | (24'(b) << (8 * pix_bytes));
                pix_bytes = pix_bytes + 2'd1;
                if ({1'b0, pix_bytes} < bpp)
                    emit = 1'b0;
            end
            else
            begin
                alpha = b;
            end
            if (emit)
            begin
                last = (rows_left == 13'd1) && ({3'b0, col} + 16'd1 == img_w);
                r.kind            = tgad_pkg::KIND_PIXEL;
                r.image_width     = img_w;
                r.image_height    = img_h;
                r.bytes_per_pixel = bpp;
                r.pixel_index     = row_base + {11'b0, col};
                r.red             = pix_acc[23:16];
                r.green           = pix_acc[15:8];
                r.blue            = pix_acc[7:0];
                r.alpha           = alpha;
                r.last_pixel      = last;
                decoded_q.push_back(r);
                pix_acc   = '0;
                pix_bytes = '0;
                col       = col + 13'd1;
                // Rows are stored bottom-up, so each finished row steps the base down.
                if ({3'b0, col} >= img_w)
                begin
                    col       = '0;
                    rows_left = rows_left - 13'd1;
                    row_base  = row_base - {8'b0, img_w};
                end
                if (last)
                    phase = PARSE_IDLE;
            end
        end
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] seen);
        if (want !== seen)
        begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, seen);
            mismatches++;
        end
    endtask

    // Compare one popped word against the oldest prediction.
    task automatic check_word(input tgad_pkg::out_word_t got);
        tgad_pkg::out_word_t want;
        if (decoded_q.size() == 0)
        begin
            $display("%0t: unexpected result word: expected none, got %p", $time, got);
            mismatches++;
        end
        else
        begin
            want = decoded_q.pop_front();
            report_field("kind", want.kind, got.kind);
            report_field("image_width", want.image_width, got.image_width);
            report_field("image_height", want.image_height, got.image_height);
            report_field("bytes_per_pixel", want.bytes_per_pixel, got.bytes_per_pixel);
            report_field("pixel_index", want.pixel_index, got.pixel_index);
            report_field("red", want.red, got.red);
            report_field("green", want.green, got.green);
            report_field("blue", want.blue, got.blue);
            report_field("alpha", want.alpha, got.alpha);
            report_field("last_pixel", want.last_pixel, got.last_pixel);
        end
    endtask

    // Watch both handshakes at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_decoder();
            decoded_q.delete();
            mismatches = 0;
            words_pending <= 0;
        end
        else
        begin
            if (push && !full)
                decode_byte(item);
            if (pop && !empty)
                check_word(result);
            words_pending <= decoded_q.size();
        end
    end

endmodule

[bench/tga_truecolor_stream_decoder_top_tb.sv]
// Top of the TGA stream decoder testbench: clock, reset, stimulus, draining and verdict.
`timescale 1ns / 1ps

module tga_truecolor_stream_decoder_top_tb;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_BYTES = 100;
    localparam int HOLD_AT      = 8;
    localparam int LONG_HOLD    = 500;
    localparam int DRAIN_CYCLES = 10;

    logic                clk   = 1'b0;
    logic                rst_n = 1'b0;
    logic                push  = 1'b0;
    logic                pop   = 1'b0;
    tgad_pkg::in_word_t  item  = '0;
    logic                full;
    logic                empty;
    tgad_pkg::out_word_t result;
    int                  fail_count;
    int                  words_pending;
    int                  cycle_count  = 0;
    int                  stream_bytes = 0;
    int                  words_popped = 0;
    bit                  sender_burst = 1'b0;
    bit                  reader_burst = 1'b0;

    always #2 clk = ~clk;

    tga_truecolor_stream_decoder_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    tga_truecolor_stream_decoder_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .item          (item),
        .empty         (empty),
        .pop           (pop),
        .result        (result),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    // Guard against a hung run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offer one byte after a random gap and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic fs, input bit counted);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item.data_byte  <= b;
        item.file_start <= fs;
        do
            @(posedge clk);
        while (full);
        if (counted)
            stream_bytes++;
    endtask

    // Bytes that arrive while the decoder is idle and must be dropped.
    task automatic send_idle(input int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom), 1'b0, 1'b0);
    endtask

    // Send the first hdr_len header bytes, then pix_len random pixel bytes.
    task automatic send_file(input logic [7:0] ftype, input logic [15:0] w,
                             input logic [15:0] h, input logic [7:0] dep,
                             input logic [7:0] desc, input int hdr_len, input int pix_len);
        logic [7:0] hdr [18];
        for (int i = 0; i < 18; i++)
            hdr[i] = 8'($urandom);
        hdr[tgad_pkg::POS_TYPE]      = ftype;
        hdr[tgad_pkg::POS_WIDTH_LO]  = w[7:0];
        hdr[tgad_pkg::POS_WIDTH_HI]  = w[15:8];
        hdr[tgad_pkg::POS_HEIGHT_LO] = h[7:0];
        hdr[tgad_pkg::POS_HEIGHT_HI] = h[15:8];
        hdr[tgad_pkg::POS_DEPTH]     = dep;
        hdr[tgad_pkg::POS_DESC]      = desc;
        for (int i = 0; i < hdr_len; i++)
            send_byte(hdr[i], i == 0, 1'b1);
        for (int i = 0; i < pix_len; i++)
            send_byte(8'($urandom), 1'b0, 1'b1);
    endtask

    function automatic int image_bytes(input logic [15:0] w, input logic [15:0] h,
                                       input logic [7:0] dep);
        return int'(w) * int'(h) * ((dep == tgad_pkg::DEPTH_32) ? 4 : 3);
    endfunction

    task automatic send_image(input logic [15:0] w, input logic [15:0] h,
                              input logic [7:0] dep, input logic [7:0] desc);
        send_file(tgad_pkg::TYPE_TRUECOLOR, w, h, dep, desc, 18, image_bytes(w, h, dep));
    endtask

    // Any descriptor the decoder accepts: low nibble 0 or 8, upper bits free.
    function automatic logic [7:0] good_desc();
        logic [7:0] d;
        d = 8'($urandom);
        d[3:0] = $urandom_range(0, 1) ? tgad_pkg::ORIGIN_ALPHA8 : tgad_pkg::ORIGIN_LOWER;
        return d;
    endfunction

    // Result side: random pop gaps, stretches without gaps, and one long hold.
    initial
    begin
        int gap;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = reader_burst ? 0 : $urandom_range(0, 3);
            if (words_popped == HOLD_AT)
                gap = LONG_HOLD;
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            words_popped++;
            if (words_popped % 64 == 0)
                reader_burst = !reader_burst;
        end
    end

    // Byte stream: directed files first, then random files.
    initial
    begin
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  t;
        logic [7:0]  dep;
        logic [7:0]  desc;
        int          n;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bytes before any file start are dropped.
        send_idle(3);
        // Small accepted images of both depths, with idle bytes after the first one's last pixel.
        send_image(16'd2, 16'd2, tgad_pkg::DEPTH_24, 8'h00);
        send_idle(2);
        send_image(16'd3, 16'd1, tgad_pkg::DEPTH_32, 8'h08);
        send_image(16'd1, 16'd3, tgad_pkg::DEPTH_32, 8'hF0);
        // Zero sides are accepted with no pixels after the header.
        send_image(16'd0, 16'(tgad_pkg::MAX_SIDE), tgad_pkg::DEPTH_24, 8'h00);
        send_idle(2);
        send_image(16'(tgad_pkg::MAX_SIDE), 16'd0, tgad_pkg::DEPTH_32, 8'h28);
        // Unsupported type, depth, descriptor and sizes.
        send_file(8'd3, 16'd2, 16'd2, tgad_pkg::DEPTH_24, 8'h00, 18, 0);
        send_idle(2);
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'd2, 16'd2, 8'd16, 8'h00, 18, 0);
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'd2, 16'd2, tgad_pkg::DEPTH_24, 8'h02, 18, 0);
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'd1, 16'd1, tgad_pkg::DEPTH_32, 8'h0F, 18, 0);
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'(tgad_pkg::MAX_SIDE + 1), 16'd1,
                  tgad_pkg::DEPTH_24, 8'h00, 18, 0);
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'd1, 16'(tgad_pkg::MAX_SIDE + 1),
                  tgad_pkg::DEPTH_24, 8'h00, 18, 0);
        send_file(8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 18, 0);
        // A new file start in the middle of a header and in the middle of a pixel.
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'd2, 16'd2, tgad_pkg::DEPTH_24, 8'h00, 9, 0);
        send_file(tgad_pkg::TYPE_TRUECOLOR, 16'd3, 16'd3, tgad_pkg::DEPTH_24, 8'h00, 18, 10);
        send_image(16'd2, 16'd1, tgad_pkg::DEPTH_32, 8'h08);

        // Random files, mostly well formed.
        stream_bytes = 0;
        while (stream_bytes < RANDOM_BYTES)
        begin
            sender_burst = ($urandom_range(0, 3) == 0);
            w    = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 9)
                                                   : $urandom_range(1, 3));
            h    = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 9)
                                                   : $urandom_range(1, 3));
            dep  = $urandom_range(0, 1) ? tgad_pkg::DEPTH_32 : tgad_pkg::DEPTH_24;
            desc = good_desc();
            t    = tgad_pkg::TYPE_TRUECOLOR;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    send_image(w, h, dep, desc);
                    if ($urandom_range(0, 3) == 0)
                        send_idle($urandom_range(1, 3));
                end
                6:
                begin
                    // Exactly one header field out of range.
                    case ($urandom_range(0, 4))
                        0:
                        begin
                            do
                                t = 8'($urandom);
                            while (t == tgad_pkg::TYPE_TRUECOLOR);
                        end
                        1:
                        begin
                            do
                                dep = 8'($urandom);
                            while (dep == tgad_pkg::DEPTH_24 || dep == tgad_pkg::DEPTH_32);
                        end
                        2:
                        begin
                            do
                                desc[3:0] = 4'($urandom);
                            while (desc[3:0] == tgad_pkg::ORIGIN_LOWER
                                   || desc[3:0] == tgad_pkg::ORIGIN_ALPHA8);
                        end
                        3: w = 16'($urandom_range(tgad_pkg::MAX_SIDE + 1, 65535));
                        default: h = 16'($urandom_range(tgad_pkg::MAX_SIDE + 1, 65535));
                    endcase
                    send_file(t, w, h, dep, desc, 18, 0);
                    if ($urandom_range(0, 1) == 0)
                        send_idle($urandom_range(1, 3));
                end
                7:
                    send_file(t, w, h, dep, desc, $urandom_range(1, 17), 0);
                8:
                begin
                    n = image_bytes(w, h, dep);
                    send_file(t, w, h, dep, desc, 18, (n > 0) ? $urandom_range(0, n - 1) : 0);
                end
                default:
                begin
                    // Noise: a file start and random bytes with an occasional restart.
                    send_byte(8'($urandom), 1'b1, 1'b1);
                    n = $urandom_range(0, 24);
                    for (int i = 0; i < n; i++)
                        send_byte(8'($urandom), $urandom_range(0, 15) == 0, 1'b1);
                end
            endcase
        end
        push <= 1'b0;

        // Let the pipeline drain, then give the verdict.
        repeat (2) @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
